// ===== hdl/swm_pkg.sv =====
// Shared constants and types for the sliding window median filter.
package swm_pkg;

  localparam int WINDOW_MAX_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int CFG_W           = 7;
  localparam int SUM_W           = 63;
  localparam logic [CFG_W-1:0] WIN_LEN_RESET = 7'd3;

  typedef struct packed {
    logic load;
    logic clear;
    logic full;
    logic shift;
  } cell_ctrl_t;

endpackage

// ===== hdl/swm_cell.sv =====
// One slot of the sorted window: held sample, age, history tap and scan stage.
module swm_cell #(
  parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF,
  parameter int INDEX       = 0,
  localparam int LEN_W      = $clog2(WINDOW_MAX + 1),
  localparam int AGE_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  swm_pkg::cell_ctrl_t    ctrl,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic [SAMPLE_BITS-1:0] drop_value,
  input  logic [LEN_W-1:0]       fill_next,
  input  logic [LEN_W-1:0]       win_len,
  input  logic                   left_valid,
  input  logic [SAMPLE_BITS-1:0] left_value,
  input  logic [AGE_W-1:0]       left_age,
  input  logic                   left_shift_r,
  input  logic                   right_valid,
  input  logic [SAMPLE_BITS-1:0] right_value,
  input  logic [AGE_W-1:0]       right_age,
  input  logic                   right_shift_l,
  input  logic [SAMPLE_BITS-1:0] hist_in,
  input  logic [SAMPLE_BITS-1:0] scan_val_in,
  input  logic                   scan_elig_in,
  output logic                   valid,
  output logic [SAMPLE_BITS-1:0] value,
  output logic [AGE_W-1:0]       age,
  output logic                   shift_l,
  output logic                   shift_r,
  output logic [SAMPLE_BITS-1:0] hist,
  output logic [SAMPLE_BITS-1:0] scan_val,
  output logic                   scan_elig
);

  logic                   del;
  logic                   after_del;
  logic                   gt;
  logic                   take_left;
  logic                   take_self;
  logic                   take_right;
  logic                   valid_pre;
  logic [SAMPLE_BITS-1:0] value_pre;
  logic [AGE_W-1:0]       age_pre;
  logic                   elig_pre;

  // order is value ascending, oldest first among equals
  assign del        = ctrl.full & valid & (age == AGE_W'(WINDOW_MAX - 1));
  assign after_del  = ctrl.full & valid & ~del & (value >= drop_value);
  assign gt         = valid & ~del & (value > sample);
  assign shift_l    = valid & ~del & after_del & ~gt;
  assign shift_r    = valid & ~del & ~after_del & gt;
  assign take_left  = left_valid & left_shift_r;
  assign take_right = right_valid & right_shift_l;
  assign take_self  = valid & ~del & (after_del == gt);
  assign valid_pre  = LEN_W'(INDEX) < fill_next;

  always_comb begin
    value_pre = sample;
    age_pre   = '0;
    if (take_left) begin
      value_pre = left_value;
      age_pre   = left_age + AGE_W'(1);
    end else if (take_self) begin
      value_pre = value;
      age_pre   = age + AGE_W'(1);
    end else if (take_right) begin
      value_pre = right_value;
      age_pre   = right_age + AGE_W'(1);
    end
  end

  assign elig_pre = valid_pre & (LEN_W'(age_pre) < win_len);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= 1'b0;
      scan_elig <= 1'b0;
    end else if (ctrl.load) begin
      valid     <= valid_pre & ~ctrl.clear;
      scan_elig <= elig_pre;
    end else if (ctrl.shift) begin
      scan_elig <= scan_elig_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      value    <= value_pre;
      age      <= age_pre;
      hist     <= hist_in;
      scan_val <= value_pre;
    end else if (ctrl.shift) begin
      scan_val <= scan_val_in;
    end
  end

  a_one_source: assert property (@(posedge clk) disable iff (rst)
    ctrl.load |-> $onehot0({take_left, take_self, take_right}))
    else $error("cell %0d fed from more than one source", INDEX);

endmodule

// ===== hdl/sliding_window_median_top.sv =====
// Sliding window median filter: cell chain, median scan and output register.
//
// channel   dir  handshake               payload
// s_axis    in   tvalid/tready           tdata: sample; tlast: last_sample
// m_axis    out  tvalid/tready           tdata: median_value, median_total;
//                                        tuser: median_valid; tlast: sequence_done
// cfg       in   cfg_wr_en               cfg_wr_data: window_len
//
// A transaction updates the whole cell chain in its accept cycle; the median is then
// found by shifting a snapshot of the chain past a counter, one cell per cycle.
// Without a valid median no cell is shifted; else the scan shifts until the median's
// sorted slot reaches the head of the chain.
// Reset is synchronous; no clearing pass. A stalled output only delays the scan finish.
module sliding_window_median_top #(
  parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF,
  localparam int LEN_W      = $clog2(WINDOW_MAX + 1),
  localparam int AGE_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1,
  localparam int IN_W       = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_W      = ((SAMPLE_BITS + swm_pkg::SUM_W + 7) / 8) * 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [IN_W-1:0]           s_axis_tdata,   // sample
  input  logic                      s_axis_tlast,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [OUT_W-1:0]          m_axis_tdata,   // median_value, median_total
  output logic                      m_axis_tuser,   // median_valid
  output logic                      m_axis_tlast,
  input  logic                      cfg_wr_en,
  input  logic [swm_pkg::CFG_W-1:0] cfg_wr_data
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t                      state;
  state_t                      state_next;
  logic [swm_pkg::CFG_W-1:0]   win_len_cfg;
  logic [LEN_W-1:0]            len_eff;
  logic [LEN_W-1:0]            fill;
  logic [LEN_W-1:0]            fill_next;
  logic                        full;
  logic                        accept;
  logic [SAMPLE_BITS-1:0]      sample;
  logic                        pend_valid;
  logic                        pend_last;
  logic [LEN_W-1:0]            want;
  logic [LEN_W-1:0]            seen;
  logic                        hit;
  logic                        done;
  logic                        out_free;
  logic                        finish;
  logic                        shift;
  logic [SAMPLE_BITS-1:0]      med;
  logic [swm_pkg::SUM_W-1:0]   sum;
  logic [swm_pkg::SUM_W-1:0]   total_next;
  logic [SAMPLE_BITS-1:0]      out_med;
  logic [swm_pkg::SUM_W-1:0]   out_total;
  swm_pkg::cell_ctrl_t         ctrl;

  logic                        c_valid     [WINDOW_MAX];
  logic [SAMPLE_BITS-1:0]      c_value     [WINDOW_MAX];
  logic [AGE_W-1:0]            c_age       [WINDOW_MAX];
  logic                        c_shift_l   [WINDOW_MAX];
  logic                        c_shift_r   [WINDOW_MAX];
  logic [SAMPLE_BITS-1:0]      c_hist      [WINDOW_MAX];
  logic [SAMPLE_BITS-1:0]      c_scan_val  [WINDOW_MAX];
  logic                        c_scan_elig [WINDOW_MAX];

  assign sample        = s_axis_tdata[SAMPLE_BITS-1:0];
  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid & s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_len_cfg <= swm_pkg::WIN_LEN_RESET;
    end else if (cfg_wr_en) begin
      win_len_cfg <= cfg_wr_data;
    end
  end

  always_comb begin
    if (win_len_cfg == '0) begin
      len_eff = LEN_W'(1);
    end else if (32'(win_len_cfg) > WINDOW_MAX) begin
      len_eff = LEN_W'(WINDOW_MAX);
    end else begin
      len_eff = LEN_W'(win_len_cfg);
    end
  end

  assign full      = (fill == LEN_W'(WINDOW_MAX));
  assign fill_next = full ? fill : fill + LEN_W'(1);

  assign ctrl.load  = accept;
  assign ctrl.clear = accept & s_axis_tlast;
  assign ctrl.full  = full;
  assign ctrl.shift = shift;

  genvar i;
  generate
    for (i = 0; i < WINDOW_MAX; i++) begin : g_cell
      logic                   l_valid;
      logic [SAMPLE_BITS-1:0] l_value;
      logic [AGE_W-1:0]       l_age;
      logic                   l_shift_r;
      logic [SAMPLE_BITS-1:0] l_hist;
      logic                   r_valid;
      logic [SAMPLE_BITS-1:0] r_value;
      logic [AGE_W-1:0]       r_age;
      logic                   r_shift_l;
      logic [SAMPLE_BITS-1:0] r_scan_val;
      logic                   r_scan_elig;

      if (i == 0) begin : g_first
        assign l_valid   = 1'b0;
        assign l_value   = '0;
        assign l_age     = '0;
        assign l_shift_r = 1'b0;
        assign l_hist    = sample;
      end else begin : g_mid_l
        assign l_valid   = c_valid[i-1];
        assign l_value   = c_value[i-1];
        assign l_age     = c_age[i-1];
        assign l_shift_r = c_shift_r[i-1];
        assign l_hist    = c_hist[i-1];
      end

      if (i == WINDOW_MAX - 1) begin : g_last
        assign r_valid     = 1'b0;
        assign r_value     = '0;
        assign r_age       = '0;
        assign r_shift_l   = 1'b0;
        assign r_scan_val  = '0;
        assign r_scan_elig = 1'b0;
      end else begin : g_mid_r
        assign r_valid     = c_valid[i+1];
        assign r_value     = c_value[i+1];
        assign r_age       = c_age[i+1];
        assign r_shift_l   = c_shift_l[i+1];
        assign r_scan_val  = c_scan_val[i+1];
        assign r_scan_elig = c_scan_elig[i+1];
      end

      swm_cell #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS),
        .INDEX       (i)
      ) u_cell (
        .clk           (clk),
        .rst           (rst),
        .ctrl          (ctrl),
        .sample        (sample),
        .drop_value    (c_hist[WINDOW_MAX-1]),
        .fill_next     (fill_next),
        .win_len       (len_eff),
        .left_valid    (l_valid),
        .left_value    (l_value),
        .left_age      (l_age),
        .left_shift_r  (l_shift_r),
        .right_valid   (r_valid),
        .right_value   (r_value),
        .right_age     (r_age),
        .right_shift_l (r_shift_l),
        .hist_in       (l_hist),
        .scan_val_in   (r_scan_val),
        .scan_elig_in  (r_scan_elig),
        .valid         (c_valid[i]),
        .value         (c_value[i]),
        .age           (c_age[i]),
        .shift_l       (c_shift_l[i]),
        .shift_r       (c_shift_r[i]),
        .hist          (c_hist[i]),
        .scan_val      (c_scan_val[i]),
        .scan_elig     (c_scan_elig[i])
      );
    end
  endgenerate

  // median scan at the head of the snapshot chain
  assign hit        = c_scan_elig[0] & (seen == want);
  assign done       = ~pend_valid | hit;
  assign out_free   = ~m_axis_tvalid | m_axis_tready;
  assign finish     = (state == ST_SCAN) & done & out_free;
  assign shift      = (state == ST_SCAN) & ~done;
  assign med        = pend_valid ? c_scan_val[0] : '0;
  assign total_next = sum + swm_pkg::SUM_W'(med);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (finish) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      fill          <= '0;
      sum           <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        fill <= s_axis_tlast ? '0 : fill_next;
      end
      if (finish) begin
        sum           <= pend_last ? '0 : total_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_valid <= (fill_next >= len_eff);
      pend_last  <= s_axis_tlast;
      want       <= (len_eff - LEN_W'(1)) >> 1;
      seen       <= '0;
    end else if (shift) begin
      seen <= seen + LEN_W'(c_scan_elig[0]);
    end
    if (finish) begin
      out_med      <= med;
      out_total    <= total_next;
      m_axis_tuser <= pend_valid;
      m_axis_tlast <= pend_last;
    end
  end

  assign m_axis_tdata = OUT_W'({out_total, out_med});

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= LEN_W'(WINDOW_MAX))
    else $error("fill count above window capacity");

  a_no_overshoot: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && pend_valid) |-> seen <= want)
    else $error("median scan ran past the wanted rank");

  a_clear_on_last: assert property (@(posedge clk) disable iff (rst)
    (accept && s_axis_tlast) |=> (fill == '0 && !c_valid[0]))
    else $error("window not cleared after last sample");

endmodule
